/* design/bdl_pkg.sv */
// Shared types for the bounded double-ended list.
// Holds the cell control group, the status codes and the result record.
// No dependencies.
package bdl_pkg;

  // Status codes carried with every result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_head;
    logic rem_head;
    logic ins_tail;
    logic rd_load;
    logic rd_shift;
  } cell_ctrl_t;

  // One finished result as it waits in the output buffer.
  typedef struct packed {
    status_t     status;
    logic [8:0]  entry_count;
    logic [31:0] read_data;
  } result_t;

endpackage

/* design/bounded_double_ended_list_top.sv */
// Inserts, removes, head reads and errors put their result in the output buffer on acceptance;
// a read at position k >= 1 first walks the read line toward the head, 1 cell a cycle.
// Throughput: 1 transaction per cycle while the output buffer has room and no read walk runs.
// Reset (rst, synchronous, active high) empties the list, idles control and drops results.
// Cell contents are not cleared; only entries below the count are ever read.
// Depends on bdl_pkg, bdl_cell and bdl_out_queue.
module bounded_double_ended_list_top #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // entry_data [31:0], item_index [39:32]
  input  logic [2:0]  s_tuser,   // op [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // read_data [31:0], entry_count [40:32], zero pad [47:41]
  output logic [1:0]  m_tuser    // status [1:0]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  // Operation codes of the input transaction. Code 7 is a no-operation.
  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_REM_HEAD = 3'd2,
    OP_REM_TAIL = 3'd3,
    OP_RD_HEAD  = 3'd4,
    OP_RD_TAIL  = 3'd5,
    OP_RD_INDEX = 3'd6
  } op_t;

  // WALK is entered while the read line moves a word toward the head.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [IDX_W-1:0]    walk_left, walk_left_next;

  logic                accept;
  logic                q_full;
  logic                push;
  bdl_pkg::result_t    push_res;
  bdl_pkg::result_t    out_res;
  bdl_pkg::cell_ctrl_t ctrl;

  logic [2:0]          op_bits;
  logic [31:0]         entry_data;
  logic [7:0]          item_index;
  logic [63:0]         in_wide;
  logic [63:0]         head_wide;
  logic [63:0]         tap_wide;
  logic [DATA_WIDTH-1:0] new_word;
  logic [CMP_W-1:0]    count_ext;
  logic [CMP_W-1:0]    rd_pos;
  logic                list_empty;
  logic                list_full;

  logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_word   [CAPACITY];

  assign op_bits    = s_tuser;
  assign entry_data = s_tdata[31:0];
  assign item_index = s_tdata[39:32];

  // Words are kept to DATA_WIDTH bits inside and shown as 32 bits outside.
  assign in_wide   = 64'(entry_data);
  assign new_word  = in_wide[DATA_WIDTH-1:0];
  assign head_wide = 64'(cell_word[0]);
  assign tap_wide  = 64'(rd_word[1]);

  assign count_ext  = CMP_W'(count);
  assign list_empty = (count == '0);
  assign list_full  = (count == CNT_W'(CAPACITY));

  assign s_tready = (state == S_IDLE) && !q_full;
  assign accept   = s_tvalid && s_tready;

  // Position that a read transaction targets, counted from the head.
  always_comb begin
    rd_pos = '0;
    if (op_bits == OP_RD_TAIL) begin
      rd_pos = count_ext - CMP_W'(1);
    end else if (op_bits == OP_RD_INDEX) begin
      rd_pos = CMP_W'(item_index);
    end
  end

  // Decode of the accepted transaction and of the read walk.
  always_comb begin
    state_next     = state;
    count_next     = count;
    walk_left_next = walk_left;
    ctrl           = '0;
    push           = 1'b0;
    push_res.status      = bdl_pkg::ST_OK;
    push_res.read_data   = '0;
    push_res.entry_count = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          push = 1'b1;
          unique case (op_bits)
            OP_INS_HEAD, OP_INS_TAIL: begin
              if (list_full) begin
                push_res.status = bdl_pkg::ST_FULL;
              end else begin
                ctrl.ins_head = (op_bits == OP_INS_HEAD);
                ctrl.ins_tail = (op_bits == OP_INS_TAIL);
                count_next    = count + CNT_W'(1);
              end
            end
            OP_REM_HEAD, OP_REM_TAIL: begin
              if (list_empty) begin
                push_res.status = bdl_pkg::ST_EMPTY;
              end else begin
                ctrl.rem_head = (op_bits == OP_REM_HEAD);
                count_next    = count - CNT_W'(1);
              end
            end
            OP_RD_HEAD, OP_RD_TAIL, OP_RD_INDEX: begin
              priority if (list_empty) begin
                push_res.status = bdl_pkg::ST_EMPTY;
              end else if (rd_pos >= count_ext) begin
                push_res.status = bdl_pkg::ST_RANGE;
              end else if (rd_pos == '0) begin
                push_res.read_data = head_wide[31:0];
              end else begin
                // Snapshot the list into the read line and walk it to the head.
                push           = 1'b0;
                ctrl.rd_load   = 1'b1;
                walk_left_next = IDX_W'(rd_pos);
                state_next     = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (walk_left == IDX_W'(1)) begin
          // The wanted word sits one tap away from the head.
          push               = 1'b1;
          push_res.read_data = tap_wide[31:0];
          state_next         = S_IDLE;
        end else begin
          ctrl.rd_shift  = 1'b1;
          walk_left_next = walk_left - IDX_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    push_res.entry_count = 9'(count_next);
  end

  always_ff @(posedge clk) begin
    walk_left <= walk_left_next;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // The chain: each cell takes from its neighbor on head inserts and removes.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_word;
    logic [DATA_WIDTH-1:0] next_word;
    logic [DATA_WIDTH-1:0] next_rd;

    if (i == 0) begin : g_first
      assign prev_word = new_word;
    end else begin : g_inner_prev
      assign prev_word = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_word = cell_word[i];
      assign next_rd   = '0;
    end else begin : g_inner_next
      assign next_word = cell_word[i+1];
      assign next_rd   = rd_word[i+1];
    end

    bdl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .tail_pos     (count),
      .new_word     (new_word),
      .from_prev    (prev_word),
      .from_next    (next_word),
      .rd_from_next (next_rd),
      .word         (cell_word[i]),
      .rd_word      (rd_word[i])
    );
  end

  // Finished results wait here so the list can take the next transaction.
  bdl_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_res),
    .full      (q_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {7'b0, out_res.entry_count, out_res.read_data};
  assign m_tuser = out_res.status;

endmodule

/* design/bdl_cell.sv */
// One storage cell of the list chain plus its tap of the read shift line.
// Depends on bdl_pkg for the cell control group.
module bdl_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 9,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  bdl_pkg::cell_ctrl_t    ctrl,
  input  logic [CNT_W-1:0]       tail_pos,
  input  logic [DATA_WIDTH-1:0]  new_word,
  input  logic [DATA_WIDTH-1:0]  from_prev,
  input  logic [DATA_WIDTH-1:0]  from_next,
  input  logic [DATA_WIDTH-1:0]  rd_from_next,
  output logic [DATA_WIDTH-1:0]  word,
  output logic [DATA_WIDTH-1:0]  rd_word
);

  always_ff @(posedge clk) begin
    priority if (ctrl.ins_head) begin
      word <= from_prev;
    end else if (ctrl.rem_head) begin
      word <= from_next;
    end else if (ctrl.ins_tail && (tail_pos == CNT_W'(INDEX))) begin
      word <= new_word;
    end else begin
      word <= word;
    end
  end

  // The read line takes a snapshot of the list, then moves toward the head.
  always_ff @(posedge clk) begin
    priority if (ctrl.rd_load) begin
      rd_word <= word;
    end else if (ctrl.rd_shift) begin
      rd_word <= rd_from_next;
    end else begin
      rd_word <= rd_word;
    end
  end

endmodule

/* design/bdl_out_queue.sv */
// Two-entry output buffer that decouples result delivery from the list.
// Depends on bdl_pkg for the result record.
module bdl_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bdl_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output bdl_pkg::result_t  out_data
);

  bdl_pkg::result_t slot0, slot0_next;
  bdl_pkg::result_t slot1, slot1_next;
  logic             valid0, valid0_next;
  logic             valid1, valid1_next;
  logic             pop;

  assign pop       = valid0 && out_ready;
  assign full      = valid1;
  assign out_valid = valid0;
  assign out_data  = slot0;

  always_comb begin
    slot0_next  = slot0;
    slot1_next  = slot1;
    valid0_next = valid0;
    valid1_next = valid1;
    if (pop) begin
      slot0_next  = slot1;
      valid0_next = valid1;
      valid1_next = 1'b0;
    end
    if (push) begin
      if (!valid0_next) begin
        slot0_next  = push_data;
        valid0_next = 1'b1;
      end else begin
        slot1_next  = push_data;
        valid1_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else begin
      valid0 <= valid0_next;
      valid1 <= valid1_next;
    end
  end

endmodule

/* tb/bounded_double_ended_list_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bounded_double_ended_list_top: a directed table, then
// random grow, mixed and drain phases, checked by a list predictor or typed row values.
// Depends on bdl_pkg and the design files under design/.
module bounded_double_ended_list_top_tb;

  localparam int CAPACITY = 256;
  localparam int DATA_WIDTH = 32;
  // The longest read walks the whole chain, so this covers the slowest result.
  localparam int DRAIN_CYCLES = CAPACITY + 40;

  // Operation codes as they travel in s_tuser.
  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_REM_HEAD = 3'd2,
    OP_REM_TAIL = 3'd3,
    OP_RD_HEAD  = 3'd4,
    OP_RD_TAIL  = 3'd5,
    OP_RD_INDEX = 3'd6,
    OP_NOP      = 3'd7
  } list_op_t;

  typedef enum int {PH_GROW, PH_MIXED, PH_DRAIN} phase_t;

  // One row of the directed table. When has_want is set the row carries its
  // own expected result; otherwise the predictor supplies it.
  typedef struct {
    list_op_t          op;
    logic [31:0]       word;
    logic [7:0]        idx;
    bit                has_want;
    bdl_pkg::result_t  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // entry_data [31:0], item_index [39:32]
  logic [2:0]  s_tuser = '0;   // op [2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // read_data [31:0], entry_count [40:32], zero pad [47:41]
  logic [1:0]  m_tuser;        // status [1:0]

  // Predictor state: the list contents and its length.
  logic [DATA_WIDTH-1:0] list_cells [CAPACITY];
  int                    list_count = 0;

  // Results the block still owes us, oldest first.
  bdl_pkg::result_t pending_results [$];
  int               mismatch_count = 0;

  // Idle switches for each side, and a hold-off length for the receiver.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold_cycles = 0;

  bounded_double_ended_list_top #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Directed rows. The typed expectations cover the empty-list errors, the
  // range errors, the unused op code and results that are obvious by eye.
  stim_row_t directed_rows [19] = '{
    '{OP_RD_HEAD,  32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_EMPTY, 9'd0, 32'h0}},
    '{OP_RD_TAIL,  32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_EMPTY, 9'd0, 32'h0}},
    // On an empty list the empty status wins over the index check.
    '{OP_RD_INDEX, 32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_EMPTY, 9'd0, 32'h0}},
    '{OP_REM_HEAD, 32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_EMPTY, 9'd0, 32'h0}},
    '{OP_REM_TAIL, 32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_EMPTY, 9'd0, 32'h0}},
    '{OP_NOP,      32'hFFFF_FFFF, 8'hFF, 1'b1, '{bdl_pkg::ST_OK,    9'd0, 32'h0}},
    '{OP_INS_TAIL, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{bdl_pkg::ST_OK,    9'd1, 32'h0}},
    '{OP_INS_HEAD, 32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_OK,    9'd2, 32'h0}},
    '{OP_INS_HEAD, 32'hA5A5_A5A5, 8'h5A, 1'b0, '{bdl_pkg::ST_OK,    9'd0, 32'h0}},
    '{OP_INS_TAIL, 32'h5A5A_5A5A, 8'hA5, 1'b0, '{bdl_pkg::ST_OK,    9'd0, 32'h0}},
    '{OP_RD_HEAD,  32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_OK,    9'd4, 32'hA5A5_A5A5}},
    '{OP_RD_TAIL,  32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_OK,    9'd4, 32'h5A5A_5A5A}},
    '{OP_RD_INDEX, 32'h0000_0000, 8'h02, 1'b0, '{bdl_pkg::ST_OK,    9'd0, 32'h0}},
    '{OP_RD_INDEX, 32'h0000_0000, 8'h04, 1'b1, '{bdl_pkg::ST_RANGE, 9'd4, 32'h0}},
    '{OP_RD_INDEX, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{bdl_pkg::ST_RANGE, 9'd4, 32'h0}},
    '{OP_REM_HEAD, 32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_OK,    9'd3, 32'h0}},
    '{OP_REM_TAIL, 32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_OK,    9'd2, 32'h0}},
    '{OP_NOP,      32'h0000_0000, 8'h00, 1'b1, '{bdl_pkg::ST_OK,    9'd2, 32'h0}},
    '{OP_RD_INDEX, 32'h0000_0000, 8'h01, 1'b0, '{bdl_pkg::ST_OK,    9'd0, 32'h0}}
  };

  // Reads one position of the predicted list, with the same error priority
  // as the block: an empty list first, then a position past the count.
  function automatic logic [31:0] peek_entry(int pos, output bdl_pkg::status_t st);
    if (list_count == 0) begin
      st = bdl_pkg::ST_EMPTY;
      return '0;
    end
    if (pos >= list_count) begin
      st = bdl_pkg::ST_RANGE;
      return '0;
    end
    st = bdl_pkg::ST_OK;
    return 32'(list_cells[pos]);
  endfunction

  // Applies one operation to the predicted list and returns the result the
  // block must produce for it.
  function automatic bdl_pkg::result_t apply_list_op(list_op_t op, logic [31:0] word,
                                                     logic [7:0] idx);
    bdl_pkg::result_t res;
    bdl_pkg::status_t st;
    int               i;
    res.read_data = '0;
    st = bdl_pkg::ST_OK;
    case (op)
      OP_INS_HEAD: begin
        if (list_count >= CAPACITY) begin
          st = bdl_pkg::ST_FULL;
        end else begin
          for (i = list_count; i > 0; i--) list_cells[i] = list_cells[i-1];
          list_cells[0] = word[DATA_WIDTH-1:0];
          list_count++;
        end
      end
      OP_INS_TAIL: begin
        if (list_count >= CAPACITY) begin
          st = bdl_pkg::ST_FULL;
        end else begin
          list_cells[list_count] = word[DATA_WIDTH-1:0];
          list_count++;
        end
      end
      OP_REM_HEAD: begin
        if (list_count == 0) begin
          st = bdl_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
          list_count--;
        end
      end
      OP_REM_TAIL: begin
        if (list_count == 0) st = bdl_pkg::ST_EMPTY;
        else list_count--;
      end
      OP_RD_HEAD:  res.read_data = peek_entry(0, st);
      OP_RD_TAIL:  res.read_data = peek_entry(list_count == 0 ? 0 : list_count - 1, st);
      OP_RD_INDEX: res.read_data = peek_entry(int'(idx), st);
      default: ;  // the unused code leaves the list alone
    endcase
    res.entry_count = 9'(list_count);
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 200) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Offers one transaction, with random idle cycles ahead of it, and returns
  // at the edge where it is accepted. The expected result is queued there.
  task automatic offer_op(input list_op_t op, input logic [31:0] word,
                          input logic [7:0] idx, input bit has_want,
                          input bdl_pkg::result_t want);
    bdl_pkg::result_t predicted;
    while (tx_idle_on && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {idx, word};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predicted = apply_list_op(op, word, idx);
    pending_results.push_back(has_want ? want : predicted);
  endtask

  // Holds the sender until the block has returned everything it owes.
  task automatic wait_for_results;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Chooses an operation with weights that suit the phase: growing phases
  // mostly insert, draining phases mostly remove, and the mixed phase takes
  // every code alike, the unused one included.
  function automatic list_op_t pick_op(phase_t ph);
    int roll;
    roll = $urandom_range(99);
    case (ph)
      PH_GROW: begin
        if (roll < 40) return OP_INS_HEAD;
        if (roll < 80) return OP_INS_TAIL;
        if (roll < 87) return OP_RD_INDEX;
        if (roll < 93) return OP_RD_HEAD;
        if (roll < 99) return OP_RD_TAIL;
        return OP_NOP;
      end
      PH_DRAIN: begin
        if (roll < 40) return OP_REM_HEAD;
        if (roll < 80) return OP_REM_TAIL;
        if (roll < 87) return OP_RD_INDEX;
        if (roll < 93) return OP_RD_HEAD;
        if (roll < 98) return OP_RD_TAIL;
        return OP_INS_TAIL;
      end
      default: return list_op_t'($urandom_range(7));
    endcase
  endfunction

  // Runs one random phase. Half of the index reads land inside the list so
  // that the long read path is exercised, the rest anywhere in the field.
  task automatic run_phase(input phase_t ph, input int n_items);
    list_op_t          op;
    logic [7:0]        idx;
    bdl_pkg::result_t  none;
    none = '0;
    repeat (n_items) begin
      op = pick_op(ph);
      if (list_count > 0 && $urandom_range(1) == 1) idx = 8'($urandom_range(list_count - 1));
      else idx = 8'($urandom_range(255));
      offer_op(op, $urandom(), idx, 1'b0, none);
    end
  endtask

  // Receiver: a requested hold-off is counted down here; otherwise the ready
  // line idles at random while idling is switched on.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_tready <= 1'b0;
      end else if (rx_idle_on) begin
        m_tready <= ($urandom_range(99) >= 29);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker: every transaction on the result side is compared field
  // by field with the oldest expectation.
  initial begin
    bdl_pkg::result_t exp_res;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata=%h tuser=%h", m_tdata, m_tuser));
        end else begin
          exp_res = pending_results.pop_front();
          if (m_tdata[31:0] !== exp_res.read_data)
            report_mismatch($sformatf("read_data got %h want %h",
                                      m_tdata[31:0], exp_res.read_data));
          if (m_tdata[40:32] !== exp_res.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      m_tdata[40:32], exp_res.entry_count));
          if (m_tuser !== exp_res.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      m_tuser, exp_res.status));
        end
      end
    end
  end

  // Main sequence: reset, directed table, then the random phases.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r])
      offer_op(directed_rows[r].op, directed_rows[r].word, directed_rows[r].idx,
               directed_rows[r].has_want, directed_rows[r].want);

    // Sender pause: nothing more is offered until every result is back.
    s_tvalid <= 1'b0;
    wait_for_results();

    // The receiver holds off for a long stretch while the sender keeps going,
    // so the output side backs up and the input is stalled.
    rx_hold_cycles = 300;
    // Growing long enough to hit the capacity and see refused inserts.
    run_phase(PH_GROW, 360);

    // A stretch with no idling on either side, every code alike.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(PH_MIXED, 300);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // Draining past empty to see the remove and read errors again.
    run_phase(PH_DRAIN, 360);
    s_tvalid <= 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung handshake; far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
design/bdl_pkg.sv
design/bdl_cell.sv
design/bdl_out_queue.sv
design/bounded_double_ended_list_top.sv
tb/bounded_double_ended_list_top_tb.sv
